>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, held off while reset is asserted
`define WSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also covers the reset cycles
`define WSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies
package wsd_pkg;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;
  localparam logic [6:0]  LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64  = 7'd127;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [3:0]  KEY_BYTES       = 4'd4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } wsd_kind_t;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } wsd_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_closed;
  } wsd_in_t;

  typedef struct packed {
    wsd_kind_t  kind;
    logic [3:0] opcode;
    logic [7:0] data;
    logic       last;
  } wsd_out_t;

  typedef struct packed {
    logic     valid;
    wsd_out_t item;
  } wsd_res_t;

endpackage

>>> hw/rtl/wsd_parser.sv
// frame header parser and payload unmasking state machine
// depends on wsd_pkg
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  wsd_in_t     item,
  input  logic [31:0] max_payload,
  output wsd_res_t    res
);

  wsd_phase_t  phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [31:0] rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      key_r    <= '0;
      kidx_r   <= '0;
      rem_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        hdr_done;
    logic [63:0] hdr_len;
    logic [7:0]  kbyte;
    b          = item.rx_byte;
    hdr_done   = 1'b0;
    hdr_len    = len_r;
    kbyte      = '0;
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    rem_nxt    = rem_r;
    res.valid       = 1'b0;
    res.item.kind   = KIND_BYTE;
    res.item.opcode = opcode_r;
    res.item.data   = '0;
    res.item.last   = 1'b0;

    if (step) begin
      if (item.link_closed) begin
        phase_nxt     = PH_HDR0;
        res.valid     = 1'b1;
        res.item.kind = KIND_ERROR;
        res.item.last = 1'b1;
      end else begin
        case (phase_r)
          PH_HDR1: begin
            mask_nxt = b[7];
            len_nxt  = {57'd0, b[6:0]};
            if (b[6:0] == LEN_CODE_EXT16) begin
              len_nxt   = '0;
              cnt_nxt   = EXT16_BYTES;
              phase_nxt = PH_EXT;
            end else if (b[6:0] == LEN_CODE_EXT64) begin
              len_nxt   = '0;
              cnt_nxt   = EXT64_BYTES;
              phase_nxt = PH_EXT;
            end else if (b[7]) begin
              cnt_nxt   = KEY_BYTES;
              phase_nxt = PH_KEY;
            end else begin
              hdr_done = 1'b1;
              hdr_len  = {57'd0, b[6:0]};
            end
          end
          PH_EXT: begin
            len_nxt = {len_r[55:0], b};
            cnt_nxt = cnt_r - 4'd1;
            if (cnt_nxt == 4'd0) begin
              if (mask_r) begin
                cnt_nxt   = KEY_BYTES;
                phase_nxt = PH_KEY;
              end else begin
                hdr_done = 1'b1;
                hdr_len  = len_nxt;
              end
            end
          end
          PH_KEY: begin
            key_nxt = {key_r[23:0], b};
            cnt_nxt = cnt_r - 4'd1;
            if (cnt_nxt == 4'd0) begin
              hdr_done = 1'b1;
              hdr_len  = len_r;
            end
          end
          PH_DATA: begin
            // key bytes are used in arrival order, first one in the top byte
            case (kidx_r)
              2'd0:    kbyte = key_r[31:24];
              2'd1:    kbyte = key_r[23:16];
              2'd2:    kbyte = key_r[15:8];
              default: kbyte = key_r[7:0];
            endcase
            res.valid     = 1'b1;
            res.item.kind = KIND_BYTE;
            res.item.data = b ^ kbyte;
            res.item.last = (rem_r == 32'd1);
            kidx_nxt      = kidx_r + 2'd1;
            rem_nxt       = rem_r - 32'd1;
            if (rem_r == 32'd1) begin
              phase_nxt = PH_HDR0;
            end
          end
          default: begin
            // first header byte, also taken for unused phase codes
            opcode_nxt = b[3:0];
            mask_nxt   = 1'b0;
            key_nxt    = '0;
            len_nxt    = '0;
            cnt_nxt    = '0;
            kidx_nxt   = '0;
            rem_nxt    = '0;
            phase_nxt  = PH_HDR1;
          end
        endcase

        if (hdr_done) begin
          if ((hdr_len[63:32] != 32'd0) || (hdr_len[31:0] > max_payload)) begin
            phase_nxt     = PH_HDR0;
            res.valid     = 1'b1;
            res.item.kind = KIND_ERROR;
            res.item.last = 1'b1;
          end else if (hdr_len[31:0] == 32'd0) begin
            phase_nxt     = PH_HDR0;
            res.valid     = 1'b1;
            res.item.kind = KIND_EMPTY;
            res.item.last = 1'b1;
          end else begin
            kidx_nxt  = '0;
            rem_nxt   = hdr_len[31:0];
            phase_nxt = PH_DATA;
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/wsd_out_stage.sv
// result register holding one result until the receiver takes it
// depends on wsd_pkg
module wsd_out_stage import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  wsd_res_t res,
  input  logic     out_ready,
  output logic     free,
  output logic     out_valid,
  output wsd_out_t out_item
);

  logic     valid_r;
  wsd_out_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res.valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      item_r <= res.item;
    end
  end

endmodule

>>> hw/rtl/websocket_frame_deframer_unit.sv
// Websocket frame deframer. Input channel: one received byte per transfer
// (in_item.rx_byte, in_item.link_closed). Output channel: at most one
// result per input byte (kind, opcode, data, last) with valid/ready.
// Config: cfg_we/cfg_wdata write max_payload; the user must write it only while
// the block is idle, the block does not enforce this. A taken byte goes into
// the input register, then through the parser logic into the result register,
// from which its result can transfer.
// Throughput: one byte per cycle while the receiver keeps out_ready high;
// the step rate is set by the single parser state update per cycle.
// Header bytes move through without giving a result, except the one that
// completes a header into an error or an empty frame, or a lost-link byte.
// Reset (rst_n low, synchronous): parser back to the first header byte,
// both registers empty, max_payload back to 65536.
// Receiver stall: the result register holds; the input register keeps its
// byte and in_ready drops once both are full, so no byte is dropped.
// depends on wsd_pkg, wsd_parser and wsd_out_stage
module websocket_frame_deframer_unit import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  wsd_in_t     in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_out_t    out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic        in_valid_r;
  wsd_in_t     in_item_r;
  logic [31:0] max_payload_r;
  logic        free;
  logic        step;
  wsd_res_t    res;

  // a held byte steps whenever the result register can take its result
  assign step     = in_valid_r && free;
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .max_payload (max_payload_r),
    .res         (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .out_ready (out_ready),
    .free      (free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/wsd_checker.sv
// port-level checks for the websocket frame deframer, bound to the top level
// depends on wsd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wsd_checker import wsd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input wsd_out_t out_item
);

  `WSD_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result shown right after reset")
  `WSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")
  `WSD_ASSERT(a_end_last, out_valid && (out_item.kind != KIND_BYTE) |-> out_item.last, "frame end without last")
  `WSD_ASSERT(a_end_data, out_valid && (out_item.kind != KIND_BYTE) |-> (out_item.data == 8'd0), "nonzero data on frame end")
  `WSD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_item), "stalled result changed")

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (.*);

>>> dv/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 100ps
// self-checking bench for websocket_frame_deframer_unit: drives a received byte stream,
// predicts results with a behavioral deframer kept in the bench or from directed rows, and compares them
// depends on wsd_pkg and websocket_frame_deframer_unit
module tb_websocket_frame_deframer_unit;
  import wsd_pkg::*;

  localparam int unsigned LIMIT_CYCLES      = 200000;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned BYTES_PER_SETTING = 255;
  localparam int unsigned N_SETTINGS        = 6;

  // one stimulus byte; typed rows carry their error or empty-frame result
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_closed;
    logic       typed;
    logic       has_res;
    wsd_kind_t  kind;
    logic [3:0] opcode;
  } dir_row_t;

  localparam dir_row_t DIRECTED_BYTES [29] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, KIND_ERROR, 4'h0},  // link lost right after reset
    '{8'h81, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_EMPTY, 4'h1},  // zero-length frame
    '{8'h8A, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h82, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},  // masked, two bytes
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h55, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hAA, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h12, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h34, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h0F, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h7E, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},  // unmasked, 16-bit length
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h01, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h72, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},  // 64-bit length, all ones
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, KIND_ERROR, 4'h2},  // oversize
    '{8'h89, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, KIND_BYTE,  4'h0},
    '{8'h00, 1'b1, 1'b1, 1'b1, KIND_ERROR, 4'h9}   // link lost inside the length
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  wsd_in_t     in_item;
  logic        out_valid;
  logic        out_ready;
  wsd_out_t    out_item;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  dir_row_t    cur_row;

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned n_cycles = 0;
  int unsigned n_bytes = 0;
  int unsigned n_results = 0;
  int unsigned n_frames = 0;
  int unsigned n_errors = 0;

  // bench copy of the deframer state and its register
  wsd_phase_t  m_phase;
  logic [3:0]  m_opcode;
  logic        m_masked;
  logic [63:0] m_len;
  logic [3:0]  m_hdr_left;
  logic [31:0] m_key;
  logic [63:0] m_idx;
  logic [31:0] m_max_payload;
  wsd_out_t    pending_results[$];

  websocket_frame_deframer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // header complete: too long, empty, or on to the payload
  function automatic bit header_done(output wsd_out_t r);
    r = '0;
    r.opcode = m_opcode;
    r.last = 1'b1;
    m_phase = PH_HDR0;
    if (m_len > {32'd0, m_max_payload}) begin
      r.kind = KIND_ERROR;
      return 1'b1;
    end
    if (m_len == 64'd0) begin
      r.kind = KIND_EMPTY;
      return 1'b1;
    end
    m_idx = '0;
    m_phase = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_done(output wsd_out_t r);
    r = '0;
    if (m_masked) begin
      m_hdr_left = KEY_BYTES;
      m_phase = PH_KEY;
      return 1'b0;
    end
    return header_done(r);
  endfunction

  function automatic bit deframe_step(input wsd_in_t it, output wsd_out_t r);
    logic [7:0] key_byte;
    logic       fin;
    r = '0;
    r.opcode = m_opcode;
    if (it.link_closed) begin
      m_phase = PH_HDR0;
      r.kind = KIND_ERROR;
      r.last = 1'b1;
      return 1'b1;
    end
    case (m_phase)
      PH_HDR1: begin
        m_masked = it.rx_byte[7];
        m_len = '0;
        if (it.rx_byte[6:0] == LEN_CODE_EXT16 || it.rx_byte[6:0] == LEN_CODE_EXT64) begin
          m_hdr_left = (it.rx_byte[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          m_phase = PH_EXT;
          return 1'b0;
        end
        m_len = {57'd0, it.rx_byte[6:0]};
        return length_done(r);
      end
      PH_EXT: begin
        m_len = {m_len[55:0], it.rx_byte};
        m_hdr_left = m_hdr_left - 4'd1;
        if (m_hdr_left != 4'd0) return 1'b0;
        return length_done(r);
      end
      PH_KEY: begin
        m_key = {m_key[23:0], it.rx_byte};
        m_hdr_left = m_hdr_left - 4'd1;
        if (m_hdr_left != 4'd0) return 1'b0;
        return header_done(r);
      end
      PH_DATA: begin
        // key bytes cycle in arrival order
        key_byte = m_key[31 - 8 * int'(m_idx[1:0]) -: 8];
        fin = (m_idx + 64'd1 >= m_len);
        r.kind = KIND_BYTE;
        r.data = it.rx_byte ^ key_byte;
        r.last = fin;
        m_idx = m_idx + 64'd1;
        if (fin) m_phase = PH_HDR0;
        return 1'b1;
      end
      default: begin
        m_opcode = it.rx_byte[3:0];
        m_masked = 1'b0;
        m_key = '0;
        m_len = '0;
        m_idx = '0;
        m_hdr_left = '0;
        m_phase = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    wsd_out_t want;
    bit       has;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        has = deframe_step(in_item, want);
        if (cur_row.typed) begin
          has = cur_row.has_res;
          want = '{kind: cur_row.kind, opcode: cur_row.opcode, data: 8'h00, last: 1'b1};
        end
        if (has) pending_results = {pending_results, want};
        n_bytes++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d opcode %0d data %0d",
                 out_item.kind, out_item.opcode, out_item.data);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_item.kind));
          check_field("opcode", 8'(want.opcode), 8'(out_item.opcode));
          check_field("data", want.data, out_item.data);
          check_field("last", 8'(want.last), 8'(out_item.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == LIMIT_CYCLES) begin
      $error("timeout after %0d cycles, %0d results outstanding", n_cycles,
             pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall before each transfer while rx_idle_on is set
  initial begin : result_sink
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(input dir_row_t row);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{rx_byte: row.rx_byte, link_closed: row.link_closed};
    cur_row <= row;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic closed);
    send_item('{rx_byte: b, link_closed: closed, typed: 1'b0, has_res: 1'b0,
                kind: KIND_BYTE, opcode: 4'h0});
  endtask

  // hold off until every result is back and the parser has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_max_payload = value;
  endtask

  // one frame with random content, sometimes cut short by a lost link
  task automatic send_frame();
    logic [7:0]  fbytes[$];
    logic [7:0]  hdr1;
    logic [63:0] len;
    logic [31:0] key;
    bit          masked;
    int unsigned pick;
    int unsigned form;
    int unsigned n_len;
    int unsigned n_pay;
    int unsigned hdr_len;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 50) len = 64'($urandom_range(0, 12));
    else if (pick < 65) len = 64'($urandom_range(13, 140));
    else if (pick < 75) len = 64'($urandom_range(0, 65535));
    else if (pick < 85) len = {($urandom_range(0, 1) != 0) ? $urandom : 32'd0, $urandom};
    else len = {32'd0, m_max_payload} + 64'($urandom_range(0, 2)) - 64'd1;

    // short lengths sometimes in the longer encodings
    if (len < 126) form = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
    else if (len < 65536) form = $urandom_range(1, 2);
    else form = 2;
    n_len = (form == 0) ? 0 : (form == 1) ? 2 : 8;
    masked = 1'($urandom_range(0, 1));
    key = $urandom;

    fbytes = {fbytes, 8'($urandom)};
    hdr1 = {masked, (form == 0) ? len[6:0] :
                    (form == 1) ? LEN_CODE_EXT16 : LEN_CODE_EXT64};
    fbytes = {fbytes, hdr1};
    for (int i = n_len - 1; i >= 0; i--) fbytes = {fbytes, len[8 * i +: 8]};
    if (masked) for (int i = 3; i >= 0; i--) fbytes = {fbytes, key[8 * i +: 8]};
    hdr_len = fbytes.size();

    n_pay = 0;
    if (len != 0 && len <= {32'd0, m_max_payload}) n_pay = (len > 150) ? 60 : int'(len);
    repeat (n_pay) fbytes = {fbytes, 8'($urandom)};

    // long payloads always end in a lost link
    if (len > 150 && n_pay != 0) cut = hdr_len + $urandom_range(0, n_pay - 1);
    else if ($urandom_range(0, 15) == 0) cut = $urandom_range(0, fbytes.size() - 1);
    else cut = fbytes.size();

    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    foreach (fbytes[i]) begin
      if (i == cut) begin
        send_byte(8'($urandom), 1'b1);
        break;
      end
      send_byte(fbytes[i], 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [31:0] max_steps[N_SETTINGS];
    int unsigned target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cur_row = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    m_phase = PH_HDR0;
    m_opcode = '0;
    m_masked = 1'b0;
    m_len = '0;
    m_hdr_left = '0;
    m_key = '0;
    m_idx = '0;
    m_max_payload = MAX_PAYLOAD_RST;
    max_steps = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd126, 32'd0, MAX_PAYLOAD_RST};
    max_steps[4] = $urandom_range(1, 300);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_BYTES); i++) send_item(DIRECTED_BYTES[i]);

    for (int k = 0; k < N_SETTINGS; k++) begin
      write_max_payload(max_steps[k]);
      target = n_bytes + BYTES_PER_SETTING;
      while (n_bytes < target) begin
        send_frame();
        n_frames++;
      end
    end
    wait_idle();

    $display("sent %0d bytes: directed header cases plus %0d random frames over %0d limits",
             n_bytes, n_frames, N_SETTINGS);
    $display("compared %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
